// File: src/i2c_bus_recovery_sequencer_macros.svh
// Assertion macros for the bus recovery sequencer
`ifndef I2C_BUS_RECOVERY_SEQUENCER_MACROS_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_MACROS_SVH

// same-cycle implication
`define BRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bus recovery check failed");

// next-cycle implication
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bus recovery check failed");

`endif

// File: src/i2c_brs_pkg.sv
`timescale 1ns / 1ps
package i2c_brs_pkg;

	localparam int PULSE_W   = 4;
	localparam int STRETCH_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;

	localparam logic [PULSE_W-1:0]   PULSE_COUNT_RST   = 4'd9;
	localparam logic [STRETCH_W-1:0] STRETCH_LIMIT_RST = 10'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_WAIT   = 7'b0000010,
		PH_HIGH   = 7'b0000100,
		PH_STOP_A = 7'b0001000,
		PH_STOP_B = 7'b0010000,
		PH_STOP_C = 7'b0100000,
		PH_STOP_D = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic scl_low;
		logic sda_low;
		logic busy_res;
		logic done_res;
	} res_t;

	typedef struct packed {
		logic [PULSE_W-1:0]   pulse_count;
		logic [STRETCH_W-1:0] stretch_limit;
	} cfg_t;

endpackage

// File: src/i2c_brs_if.sv
`timescale 1ns / 1ps
interface i2c_brs_req_if;
	logic valid;
	logic ready;
	logic start_request;
	logic scl_level;

	modport source (output valid, output start_request, output scl_level, input ready);
	modport sink (input valid, input start_request, input scl_level, output ready);
endinterface

interface i2c_brs_res_if;
	logic valid;
	logic ready;
	logic scl_low;
	logic sda_low;
	logic busy_res;
	logic done_res;

	modport source (output valid, output scl_low, output sda_low, output busy_res,
		output done_res, input ready);
	modport sink (input valid, input scl_low, input sda_low, input busy_res,
		input done_res, output ready);
endinterface

interface i2c_brs_cfg_if
	import i2c_brs_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/i2c_bus_recovery_sequencer.sv
`timescale 1ns / 1ps
// Channel   Dir  Word
// req       in   start_request, scl_level (one half-period tick)
// res       out  scl_low, sda_low, busy_res, done_res (one per tick)
// cfg       in   index 0 pulse_count, index 1 stretch_limit
//
// One tick in, one word out, one tick per cycle while req is ready; each word is registered.
// The sequence state is updated by single-pass logic on each accepted tick.
// A two-entry output register and skid stage keep req ready for one
// stalled word; req drops only when both entries are full.
// Reset: idle, pulse_count 9, stretch_limit 100. cfg is always ready.
module i2c_bus_recovery_sequencer
	import i2c_brs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	i2c_brs_req_if.sink      req,
	i2c_brs_res_if.source    res,
	i2c_brs_cfg_if.sink      cfg
);

	cfg_t cfg_regs;
	res_t step_res, buf_res;
	logic fire;

	assign cfg.ready = 1'b1;
	assign fire      = req.valid && req.ready;

	i2c_brs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	i2c_brs_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.start_request (req.start_request),
		.scl_level     (req.scl_level),
		.cfg           (cfg_regs),
		.res           (step_res)
	);

	i2c_brs_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire),
		.push_data  (step_res),
		.push_ready (req.ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (buf_res)
	);

	assign res.scl_low  = buf_res.scl_low;
	assign res.sda_low  = buf_res.sda_low;
	assign res.busy_res = buf_res.busy_res;
	assign res.done_res = buf_res.done_res;

endmodule

// File: src/i2c_brs_cfg.sv
`timescale 1ns / 1ps
module i2c_brs_cfg
	import i2c_brs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	logic [PULSE_W-1:0]   pulse_count_q;
	logic [STRETCH_W-1:0] stretch_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q   <= PULSE_COUNT_RST;
			stretch_limit_q <= STRETCH_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PULSE_COUNT:   pulse_count_q   <= wr_data[PULSE_W-1:0];
				CFG_STRETCH_LIMIT: stretch_limit_q <= wr_data[STRETCH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.pulse_count   = pulse_count_q;
	assign cfg.stretch_limit = stretch_limit_q;

endmodule

// File: src/i2c_brs_core.sv
`timescale 1ns / 1ps
module i2c_brs_core
	import i2c_brs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic start_request,
	input  logic scl_level,
	input  cfg_t cfg,
	output res_t res
);

	phase_t               phase_q, phase_d;
	logic [PULSE_W-1:0]   pulses_q, pulses_d, pulses_inc, target;
	logic [STRETCH_W-1:0] stretch_q, stretch_d;

	assign pulses_inc = pulses_q + PULSE_W'(1);
	assign target     = (cfg.pulse_count == '0) ? PULSE_W'(1) : cfg.pulse_count;

	always_comb begin
		phase_d     = phase_q;
		pulses_d    = pulses_q;
		stretch_d   = stretch_q;
		res         = '0;
		res.busy_res = 1'b1;
		case (phase_q)
			PH_WAIT: begin
				if (!scl_level && stretch_q != '0) begin
					stretch_d = stretch_q - STRETCH_W'(1);
				end else begin
					res.scl_low = 1'b1;
					phase_d     = PH_HIGH;
				end
			end
			PH_HIGH: begin
				pulses_d = pulses_inc;
				if (pulses_inc >= target || pulses_inc == '0) begin
					phase_d = PH_STOP_A;
				end else begin
					stretch_d = cfg.stretch_limit;
					phase_d   = PH_WAIT;
				end
			end
			PH_STOP_A: begin
				res.scl_low = 1'b1;
				phase_d     = PH_STOP_B;
			end
			PH_STOP_B: begin
				res.scl_low = 1'b1;
				res.sda_low = 1'b1;
				phase_d     = PH_STOP_C;
			end
			PH_STOP_C: begin
				res.sda_low = 1'b1;
				phase_d     = PH_STOP_D;
			end
			PH_STOP_D: begin
				res.done_res = 1'b1;
				phase_d      = PH_IDLE;
			end
			default: begin
				if (start_request) begin
					pulses_d  = '0;
					stretch_d = cfg.stretch_limit;
					phase_d   = PH_WAIT;
				end else begin
					res.busy_res = 1'b0;
					phase_d      = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pulses_q  <= '0;
			stretch_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			pulses_q  <= pulses_d;
			stretch_q <= stretch_d;
		end
	end

endmodule

// File: src/i2c_brs_outbuf.sv
`timescale 1ns / 1ps
module i2c_brs_outbuf
	import i2c_brs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic push_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// File: src/i2c_brs_checker.sv
`timescale 1ns / 1ps
`include "i2c_bus_recovery_sequencer_macros.svh"
module i2c_brs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic scl_low,
	input logic sda_low,
	input logic busy_res,
	input logic done_res
);

	`BRS_ASSERT_IMPL(a_done_busy, clk, arst_n, res_valid && done_res, busy_res)
	`BRS_ASSERT_IMPL(a_done_released, clk, arst_n, res_valid && done_res, !scl_low && !sda_low)
	`BRS_ASSERT_IMPL(a_drive_busy, clk, arst_n, res_valid && (scl_low || sda_low), busy_res)
	`BRS_ASSERT_IMPL(a_stall_cause, clk, arst_n, !req_ready, res_valid)
	`BRS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

endmodule

bind i2c_bus_recovery_sequencer i2c_brs_checker u_brs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.scl_low   (res.scl_low),
	.sda_low   (res.sda_low),
	.busy_res  (res.busy_res),
	.done_res  (res.done_res)
);
